// ===== rtl/sbci_pkg.sv =====
package sbci_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned OPND_W  = 6;

	localparam logic [OPND_W-1:0] OPERAND_MASK = 6'h3f;

	typedef enum logic [1:0] {
		OPC_DX   = 2'd0,
		OPC_DY   = 2'd1,
		OPC_TOOL = 2'd2,
		OPC_DATA = 2'd3
	} opc_t;

	localparam logic [1:0] TOOL_NONE  = 2'd0;
	localparam logic [1:0] TOOL_LINE  = 2'd1;
	localparam logic [1:0] TOOL_BLOCK = 2'd2;

	localparam logic [OPND_W-1:0] SEL_COLOUR   = 6'd3;
	localparam logic [OPND_W-1:0] SEL_TARGET_X = 6'd4;
	localparam logic [OPND_W-1:0] SEL_TARGET_Y = 6'd5;

	localparam logic [1:0] KIND_LINE   = 2'd0;
	localparam logic [1:0] KIND_BLOCK  = 2'd1;
	localparam logic [1:0] KIND_COLOUR = 2'd2;

	typedef struct packed {
		logic [7:0] command_byte;
		logic       frame_end;
	} cmd_t;

	typedef struct packed {
		logic [1:0]                draw_kind;
		logic signed [COORD_W-1:0] x_start;
		logic signed [COORD_W-1:0] y_start;
		logic signed [COORD_W-1:0] x_end_or_width;
		logic signed [COORD_W-1:0] y_end_or_height;
		logic [COORD_W-1:0]        colour_value;
	} draw_t;

endpackage

// ===== rtl/sbci_if.sv =====
interface sbci_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] command_byte;
	logic       frame_end;

	modport source (output valid, output command_byte, output frame_end, input ready);
	modport sink   (input valid, input command_byte, input frame_end, output ready);
endinterface

interface sbci_draw_if;
	logic               valid;
	logic               ready;
	logic [1:0]         draw_kind;
	logic signed [31:0] x_start;
	logic signed [31:0] y_start;
	logic signed [31:0] x_end_or_width;
	logic signed [31:0] y_end_or_height;
	logic [31:0]        colour_value;

	modport source (output valid, output draw_kind, output x_start, output y_start,
		output x_end_or_width, output y_end_or_height, output colour_value, input ready);
	modport sink   (input valid, input draw_kind, input x_start, input y_start,
		input x_end_or_width, input y_end_or_height, input colour_value, output ready);
endinterface

// ===== rtl/sketch_byte_command_interpreter.sv =====
// Channel  Dir  Payload
// cmd      in   command_byte[7:0], frame_end
// draw     out  draw_kind[1:0], x_start, y_start, x_end_or_width, y_end_or_height,
//               colour_value
//
// One command per cycle sustained unless a draw result stalls; from cmd transfer to
// draw valid: input register, then decode/update into the result register.
// Reset (arst_n low) clears position, target, accumulator and sets line tool.
// A stalled draw result holds the item in the input register only if that item
// produces a result; commands without a result keep flowing.
module sketch_byte_command_interpreter (
	input  logic        clk,
	input  logic        arst_n,
	sbci_cmd_if.sink    cmd,
	sbci_draw_if.source draw
);
	import sbci_pkg::*;

	cmd_t  in_item;
	cmd_t  item_s1;
	logic  item_valid_s1;
	logic  adv;
	logic  fire;
	logic  res_valid;
	logic  out_free;
	draw_t res;

	assign in_item.command_byte = cmd.command_byte;
	assign in_item.frame_end    = cmd.frame_end;

	assign adv  = !res_valid || out_free;
	assign fire = item_valid_s1 && adv;

	sbci_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (cmd.valid),
		.in_ready      (cmd.ready),
		.in_item       (in_item),
		.adv           (adv),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	sbci_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	sbci_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire && res_valid),
		.res    (res),
		.free   (out_free),
		.draw   (draw)
	);

	a_frame_end_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && item_s1.frame_end |-> !res_valid)
		else $error("frame end produced a result");

	a_result_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid |=> draw.valid)
		else $error("result lost before output register");

	a_stall_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && !adv |=> item_valid_s1)
		else $error("stalled item dropped");

	a_ready_only_blocked_by_item: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> item_valid_s1 && res_valid && draw.valid)
		else $error("input stalled without cause");
endmodule

// ===== rtl/sbci_in_stage.sv =====
module sbci_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sbci_pkg::cmd_t in_item,
	input  logic          adv,
	output logic          item_valid_s1,
	output sbci_pkg::cmd_t item_s1
);
	import sbci_pkg::*;

	assign in_ready = !item_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end
endmodule

// ===== rtl/sbci_exec.sv =====
module sbci_exec (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  sbci_pkg::cmd_t  item,
	output logic           res_valid,
	output sbci_pkg::draw_t res
);
	import sbci_pkg::*;

	logic [COORD_W-1:0] pos_x_q, pos_y_q, target_x_q, target_y_q, acc_q;
	logic [1:0]         tool_q;
	logic [COORD_W-1:0] pos_x_d, pos_y_d, target_x_d, target_y_d, acc_d;
	logic [1:0]         tool_d;
	logic [OPND_W-1:0]  sel;
	logic [COORD_W-1:0] opnd;
	logic [COORD_W-1:0] ty_new;

	assign sel    = item.command_byte[OPND_W-1:0] & OPERAND_MASK;
	assign opnd   = {{(COORD_W-OPND_W){sel[OPND_W-1]}}, sel};
	assign ty_new = target_y_q + opnd;

	always_comb begin
		pos_x_d    = pos_x_q;
		pos_y_d    = pos_y_q;
		target_x_d = target_x_q;
		target_y_d = target_y_q;
		acc_d      = acc_q;
		tool_d     = tool_q;
		res_valid  = 1'b0;
		res        = '0;
		if (item.frame_end) begin
			pos_x_d    = '0;
			pos_y_d    = '0;
			target_x_d = '0;
			target_y_d = '0;
			acc_d      = '0;
			tool_d     = TOOL_LINE;
		end else begin
			unique case (opc_t'(item.command_byte[7:6]))
				OPC_TOOL: begin
					priority if (sel <= {4'd0, TOOL_BLOCK}) begin
						tool_d = sel[1:0];
						acc_d  = '0;
					end else if (sel == SEL_COLOUR) begin
						res_valid        = 1'b1;
						res.draw_kind    = KIND_COLOUR;
						res.colour_value = acc_q;
						acc_d            = '0;
					end else if (sel == SEL_TARGET_X) begin
						target_x_d = acc_q;
						acc_d      = '0;
					end else if (sel == SEL_TARGET_Y) begin
						target_y_d = acc_q;
						acc_d      = '0;
					end else begin
						tool_d = tool_q;
					end
				end
				OPC_DX: begin
					target_x_d = target_x_q + opnd;
				end
				OPC_DY: begin
					target_y_d = ty_new;
					res.x_start = pos_x_q;
					res.y_start = pos_y_q;
					if (tool_q == TOOL_LINE) begin
						res_valid           = 1'b1;
						res.draw_kind       = KIND_LINE;
						res.x_end_or_width  = target_x_q;
						res.y_end_or_height = ty_new;
					end else if (tool_q == TOOL_BLOCK) begin
						res_valid           = 1'b1;
						res.draw_kind       = KIND_BLOCK;
						res.x_end_or_width  = target_x_q - pos_x_q;
						res.y_end_or_height = ty_new - pos_y_q;
						acc_d               = '0;
					end else begin
						res = '0;
					end
					pos_x_d = target_x_q;
					pos_y_d = ty_new;
				end
				OPC_DATA: begin
					acc_d = {acc_q[COORD_W-OPND_W-1:0], sel};
				end
				default: begin
					acc_d = acc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			target_x_q <= '0;
			target_y_q <= '0;
			acc_q      <= '0;
			tool_q     <= TOOL_LINE;
		end else if (fire) begin
			pos_x_q    <= pos_x_d;
			pos_y_q    <= pos_y_d;
			target_x_q <= target_x_d;
			target_y_q <= target_y_d;
			acc_q      <= acc_d;
			tool_q     <= tool_d;
		end
	end
endmodule

// ===== rtl/sbci_out_stage.sv =====
module sbci_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  sbci_pkg::draw_t res,
	output logic           free,
	sbci_draw_if.source    draw
);
	import sbci_pkg::*;

	logic  valid_q;
	draw_t data_q;

	assign free = !valid_q || draw.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= res;
		end
	end

	assign draw.valid           = valid_q;
	assign draw.draw_kind       = data_q.draw_kind;
	assign draw.x_start         = data_q.x_start;
	assign draw.y_start         = data_q.y_start;
	assign draw.x_end_or_width  = data_q.x_end_or_width;
	assign draw.y_end_or_height = data_q.y_end_or_height;
	assign draw.colour_value    = data_q.colour_value;
endmodule
